/* sv/lgac_pkg.sv */
// lgac_pkg: shared types and constants of the landing-gear controller
// used by lgac_step and landing_gear_auto_controller; no dependencies
`default_nettype none

package lgac_pkg;

	// gear mode codes
	typedef enum logic [1:0] {
		MODE_RETRACT = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_AUTO    = 2'd2
	} gear_mode_t;

	// request kinds carried in the input tuser
	typedef enum logic [1:0] {
		REQ_UPDATE  = 2'd0,
		REQ_RETRACT = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_AUTO    = 2'd3
	} req_type_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_UP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_DOWN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TIMEOUT = 3'd5;
	localparam int unsigned CFG_DATA_W = 16;

	// flight mode number that means land
	localparam logic signed [7:0] LAND_MODE = 8'sd9;

	// register reset values
	localparam logic [11:0] PWM_UP_RST        = 12'd1900;
	localparam logic [11:0] PWM_DOWN_RST      = 12'd1100;
	localparam logic [15:0] DWELL_TIMEOUT_RST = 16'd3000;

	typedef struct packed {
		logic        gear_enable;
		logic [11:0] pwm_up;
		logic [11:0] pwm_down;
		logic [15:0] altitude_threshold;
		logic [15:0] speed_limit;
		logic [15:0] dwell_timeout;
	} cfg_t;

	typedef struct packed {
		gear_mode_t  gear_mode;
		logic        gear_down;
		logic        retract_wanted;
		logic [31:0] dwell_start;
	} gear_state_t;

	// one input beat, decoded
	typedef struct packed {
		req_type_t          req_type;
		logic signed [23:0] altitude_cm;
		logic [15:0]        ground_speed;
		logic [31:0]        now_ms;
		logic signed [7:0]  flight_mode;
		logic               armed;
		logic               link_lost;
		logic               batt_low;
		logic               nav_lost;
		logic               channel_assigned;
	} item_t;

	// one result beat, first field in the highest bits
	typedef struct packed {
		logic [1:0]  mode_now;
		logic        gear_is_down;
		logic [11:0] servo_pwm;
		logic        servo_write;
	} res_t;

endpackage

`default_nettype wire

/* sv/lgac_step.sv */
// lgac_step: next-state and result logic for one item of the gear controller
// depends on lgac_pkg
`default_nettype none

module lgac_step
	import lgac_pkg::*;
(
	input  cfg_t        cfg,
	input  gear_state_t cur,
	input  item_t       item,
	output gear_state_t nxt,
	output res_t        res
);

	logic [31:0]        elapsed;
	logic               dwell_over;
	logic               no_dwell;
	logic signed [24:0] alt_ext;
	logic signed [24:0] thr_ext;
	logic               alt_above;
	logic               alt_below;
	logic               speed_ok;
	logic               fs_any;

	// comparisons on the raw item and current state
	always_comb begin
		elapsed    = item.now_ms - cur.dwell_start;
		no_dwell   = (cur.dwell_start == 32'd0);
		dwell_over = (elapsed > {16'd0, cfg.dwell_timeout});
		alt_ext    = {item.altitude_cm[23], item.altitude_cm};
		thr_ext    = $signed({9'd0, cfg.altitude_threshold});
		alt_above  = (alt_ext > thr_ext);
		alt_below  = (alt_ext < thr_ext);
		speed_ok   = (item.ground_speed <= cfg.speed_limit) || (cfg.speed_limit == 16'd0);
		fs_any     = item.link_lost | item.batt_low | item.nav_lost;
	end

	// state update and servo write decision
	always_comb begin
		nxt = cur;
		res.servo_write = 1'b0;
		res.servo_pwm   = 12'd0;
		if (cfg.gear_enable) begin
			case (item.req_type)
				REQ_RETRACT: begin
					nxt.retract_wanted = 1'b1;
					nxt.gear_mode      = MODE_RETRACT;
				end
				REQ_RELEASE: begin
					nxt.retract_wanted = 1'b0;
					nxt.gear_mode      = MODE_RELEASE;
				end
				REQ_AUTO: begin
					nxt.gear_mode = MODE_AUTO;
				end
				REQ_UPDATE: begin
					if (item.channel_assigned) begin
						// auto switching with dwell
						if (cur.gear_mode == MODE_AUTO) begin
							if (cfg.altitude_threshold != 16'd0) begin
								if (cur.gear_down ? alt_above : (alt_below && speed_ok)) begin
									if (no_dwell) begin
										nxt.dwell_start = item.now_ms;
									end else if (dwell_over) begin
										nxt.retract_wanted = cur.gear_down;
									end
								end else begin
									nxt.dwell_start = 32'd0;
								end
							end
							if (!item.armed) begin
								nxt.retract_wanted = 1'b0;
							end
						end
						// land mode and failsafe overrides
						if (item.flight_mode == LAND_MODE || fs_any) begin
							nxt.retract_wanted = 1'b0;
						end
						// move the gear when request and position disagree
						if (cur.gear_down && nxt.retract_wanted) begin
							res.servo_write = 1'b1;
							res.servo_pwm   = cfg.pwm_up;
							nxt.gear_down   = 1'b0;
						end else if (!cur.gear_down && !nxt.retract_wanted) begin
							res.servo_write = 1'b1;
							res.servo_pwm   = cfg.pwm_down;
							nxt.gear_down   = 1'b1;
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
		res.gear_is_down = nxt.gear_down;
		res.mode_now     = nxt.gear_mode;
	end

endmodule

`default_nettype wire

/* sv/landing_gear_auto_controller.sv */
// landing_gear_auto_controller: top level with config registers, gear state
// and the result register; depends on lgac_pkg and lgac_step
`default_nettype none

// Landing-gear controller. Each input beat is a retract, release or auto
// command or an update tick (selected by s_tuser); every beat yields exactly
// one result beat. A beat is taken every clock cycle unless stalled, and its
// result appears on the master side in the next cycle: the whole decision is
// one pass of compare logic between the gear state registers and the result
// register, and the result register lets a new beat enter while the previous
// result is taken in the same cycle. Updates in auto mode raise the gear once
// altitude has stayed above the threshold longer than the dwell timeout and
// lower it once it has stayed below (with ground speed in limit); disarm in
// auto mode, land mode and any failsafe force the gear down. A result with
// servo_write set carries the pulse width to drive. Configuration writes are
// always accepted and must only be issued while the block is idle.

module landing_gear_auto_controller
	import lgac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata: altitude_cm[23:0], ground_speed[39:24], now_ms[71:40],
	// flight_mode[79:72], armed[80], link_lost[81], batt_low[82],
	// nav_lost[83], channel_assigned[84], zero fill[87:85]
	input  wire logic [87:0]           s_tdata,
	// s_tuser: req_type[1:0]
	input  wire logic [1:0]            s_tuser,
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: servo_write[0], servo_pwm[12:1], gear_is_down[13], mode_now[15:14]
	output logic [15:0]                m_tdata
);

	cfg_t        cfg_q;
	gear_state_t state_q;
	gear_state_t state_nxt;
	item_t       item;
	res_t        res_nxt;
	res_t        res_q;
	logic        out_valid_q;
	logic        in_beat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign in_beat   = s_tvalid && s_tready;

	// unpack the input beat
	always_comb begin
		item.req_type         = req_type_t'(s_tuser);
		item.altitude_cm      = s_tdata[23:0];
		item.ground_speed     = s_tdata[39:24];
		item.now_ms           = s_tdata[71:40];
		item.flight_mode      = s_tdata[79:72];
		item.armed            = s_tdata[80];
		item.link_lost        = s_tdata[81];
		item.batt_low         = s_tdata[82];
		item.nav_lost         = s_tdata[83];
		item.channel_assigned = s_tdata[84];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gear_enable        <= 1'b0;
			cfg_q.pwm_up             <= PWM_UP_RST;
			cfg_q.pwm_down           <= PWM_DOWN_RST;
			cfg_q.altitude_threshold <= 16'd0;
			cfg_q.speed_limit        <= 16'd0;
			cfg_q.dwell_timeout      <= DWELL_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GEAR_ENABLE:   cfg_q.gear_enable        <= cfg_data[0];
				CFG_PWM_UP:        cfg_q.pwm_up             <= cfg_data[11:0];
				CFG_PWM_DOWN:      cfg_q.pwm_down           <= cfg_data[11:0];
				CFG_ALT_THRESHOLD: cfg_q.altitude_threshold <= cfg_data;
				CFG_SPEED_LIMIT:   cfg_q.speed_limit        <= cfg_data;
				CFG_DWELL_TIMEOUT: cfg_q.dwell_timeout      <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-item decision logic
	lgac_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// gear state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.gear_mode      <= MODE_RELEASE;
			state_q.gear_down      <= 1'b0;
			state_q.retract_wanted <= 1'b0;
			state_q.dwell_start    <= 32'd0;
		end else if (in_beat) begin
			state_q <= state_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	// a held result reports the current gear position and mode
	a_res_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.gear_is_down == state_q.gear_down &&
			res_q.mode_now == state_q.gear_mode))
		else $error("result does not match gear state");

	// a servo write always flips the gear position
	a_write_flips_gear: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && res_nxt.servo_write |=> state_q.gear_down != $past(state_q.gear_down))
		else $error("servo write without gear change");

	// without a write no pulse width is reported
	a_no_write_no_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.servo_write |-> res_q.servo_pwm == 12'd0)
		else $error("pulse width reported without a write");

	// gear moves only with a servo write
	a_gear_moves_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !res_nxt.servo_write |=> $stable(state_q.gear_down))
		else $error("gear moved without a servo write");

endmodule

`default_nettype wire
